/* design/ivt_pkg.sv */
// shared types and constants of the address text validator
`timescale 1ns / 1ps

package ivt_pkg;

  // address kind, decided by the first separator
  typedef enum logic [1:0] {
    KIND_UNDECIDED = 2'd0,
    KIND_V4        = 2'd1,
    KIND_V6        = 2'd2
  } kind_e;

  // character classes produced by the front end
  typedef enum logic [2:0] {
    CLS_DIGIT = 3'd0,
    CLS_HEX   = 3'd1,
    CLS_DOT   = 3'd2,
    CLS_COLON = 3'd3,
    CLS_OTHER = 3'd4
  } cls_e;

  // classified character as it travels through the token queue
  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
    logic       last;
  } token_t;

  localparam logic [1:0] VERDICT_NEITHER = 2'd0;
  localparam logic [1:0] VERDICT_V4      = 2'd1;
  localparam logic [1:0] VERDICT_V6      = 2'd2;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;
  localparam logic [7:0] ASCII_LA    = 8'h61;
  localparam logic [7:0] ASCII_LF    = 8'h66;
  localparam logic [7:0] ASCII_UA    = 8'h41;
  localparam logic [7:0] ASCII_UF    = 8'h46;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;
  localparam logic [7:0] ASCII_COLON = 8'h3A;

  localparam logic [8:0] V4_MAX_GROUP = 9'd255;
  localparam logic [8:0] V4_BAD_GROUP = 9'd256;
  localparam logic [2:0] DIGITS_MAX   = 3'd7;
  localparam logic [3:0] GROUPS_MAX   = 4'd15;
  localparam logic [3:0] V4_SEPS      = 4'd3;
  localparam logic [3:0] V6_SEPS      = 4'd7;

endpackage

/* design/ivt_front.sv */
// front end: classifies each incoming character into a token
`timescale 1ns / 1ps

module ivt_front (
  input  logic [7:0]      character_i,
  input  logic            last_i,
  output ivt_pkg::token_t token_o
);

  logic is_dec;
  logic is_hex;
  logic [7:0] offs;

  always_comb begin
    is_dec = (character_i >= ivt_pkg::ASCII_ZERO) && (character_i <= ivt_pkg::ASCII_NINE);
    is_hex = ((character_i >= ivt_pkg::ASCII_LA) && (character_i <= ivt_pkg::ASCII_LF)) ||
             ((character_i >= ivt_pkg::ASCII_UA) && (character_i <= ivt_pkg::ASCII_UF));
    offs   = character_i - ivt_pkg::ASCII_ZERO;

    token_o.last  = last_i;
    token_o.digit = offs[3:0];
    if (is_dec) begin
      token_o.cls = ivt_pkg::CLS_DIGIT;
    end else if (is_hex) begin
      token_o.cls = ivt_pkg::CLS_HEX;
    end else if (character_i == ivt_pkg::ASCII_DOT) begin
      token_o.cls = ivt_pkg::CLS_DOT;
    end else if (character_i == ivt_pkg::ASCII_COLON) begin
      token_o.cls = ivt_pkg::CLS_COLON;
    end else begin
      token_o.cls = ivt_pkg::CLS_OTHER;
    end
  end

endmodule

/* design/ivt_token_fifo.sv */
// short token queue between the front end and the back end
`timescale 1ns / 1ps

module ivt_token_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  ivt_pkg::token_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output ivt_pkg::token_t rdata_o,
  output logic            valid_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ivt_pkg::token_t mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic wr_en, rd_en;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign wr_en   = wr_i && !full_o;
  assign rd_en   = rd_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + CW'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* design/ivt_back.sv */
// back end: per-token state update and the verdict register
`timescale 1ns / 1ps

module ivt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  input  ivt_pkg::token_t tok_i,
  output logic            tok_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [1:0]      verdict_o
);

  ivt_pkg::kind_e kind_q, kind_d;
  logic [3:0]  groups_q, groups_d;
  logic [2:0]  digits_q, digits_d;
  logic [8:0]  value_q, value_d;
  logic        lz_q, lz_d;
  logic        failed_q, failed_d;
  logic        res_valid_q, res_valid_d;
  logic [1:0]  verdict_q, verdict_d;
  logic [11:0] value_x10;
  logic [3:0]  groups_inc;
  logic        v4_ok_q, v6_ok_q, v4_ok_d, v6_ok_d;
  logic        consume;

  assign empty     = !res_valid_q;
  assign verdict_o = verdict_q;
  assign consume   = tok_valid_i && (!tok_i.last || !res_valid_q || pop);
  assign tok_pop_o = consume;

  always_comb begin
    value_x10  = ({3'b000, value_q} << 3) + ({3'b000, value_q} << 1) + {8'd0, tok_i.digit};
    groups_inc = (groups_q < ivt_pkg::GROUPS_MAX) ? groups_q + 4'd1 : groups_q;
    v4_ok_q = (digits_q >= 3'd1) && (digits_q <= 3'd3) &&
              (value_q <= ivt_pkg::V4_MAX_GROUP) && !(lz_q && (digits_q > 3'd1));
    v6_ok_q = (digits_q >= 3'd1) && (digits_q <= 3'd4);

    kind_d   = kind_q;
    groups_d = groups_q;
    digits_d = digits_q;
    value_d  = value_q;
    lz_d     = lz_q;
    failed_d = failed_q;

    if (!failed_q) begin
      case (tok_i.cls)
        ivt_pkg::CLS_DIGIT, ivt_pkg::CLS_HEX: begin
          if ((digits_q == 3'd0) && (tok_i.cls == ivt_pkg::CLS_DIGIT) &&
              (tok_i.digit == 4'd0)) begin
            lz_d = 1'b1;
          end
          if (digits_q < ivt_pkg::DIGITS_MAX) begin
            digits_d = digits_q + 3'd1;
          end
          if (tok_i.cls == ivt_pkg::CLS_HEX) begin
            if (kind_q == ivt_pkg::KIND_V4) begin
              failed_d = 1'b1;
            end else begin
              value_d = ivt_pkg::V4_BAD_GROUP;
            end
          end else if (value_q <= ivt_pkg::V4_MAX_GROUP) begin
            value_d = (value_x10 > 12'(ivt_pkg::V4_MAX_GROUP)) ?
                      ivt_pkg::V4_BAD_GROUP : value_x10[8:0];
          end
        end
        ivt_pkg::CLS_DOT: begin
          if ((kind_q == ivt_pkg::KIND_V6) || !v4_ok_q) begin
            failed_d = 1'b1;
          end else begin
            kind_d   = ivt_pkg::KIND_V4;
            groups_d = groups_inc;
            if (groups_inc > ivt_pkg::V4_SEPS) begin
              failed_d = 1'b1;
            end else begin
              digits_d = '0;
              value_d  = '0;
              lz_d     = 1'b0;
            end
          end
        end
        ivt_pkg::CLS_COLON: begin
          if ((kind_q == ivt_pkg::KIND_V4) || !v6_ok_q) begin
            failed_d = 1'b1;
          end else begin
            kind_d   = ivt_pkg::KIND_V6;
            groups_d = groups_inc;
            if (groups_inc > ivt_pkg::V6_SEPS) begin
              failed_d = 1'b1;
            end else begin
              digits_d = '0;
              value_d  = '0;
              lz_d     = 1'b0;
            end
          end
        end
        default: begin
          failed_d = 1'b1;
        end
      endcase
    end

    // group checks on the updated open group for the final verdict
    v4_ok_d = (digits_d >= 3'd1) && (digits_d <= 3'd3) &&
              (value_d <= ivt_pkg::V4_MAX_GROUP) && !(lz_d && (digits_d > 3'd1));
    v6_ok_d = (digits_d >= 3'd1) && (digits_d <= 3'd4);

    res_valid_d = res_valid_q && !pop;
    verdict_d   = verdict_q;
    if (consume && tok_i.last) begin
      res_valid_d = 1'b1;
      if (!failed_d && (kind_d == ivt_pkg::KIND_V4) &&
          (groups_d == ivt_pkg::V4_SEPS) && v4_ok_d) begin
        verdict_d = ivt_pkg::VERDICT_V4;
      end else if (!failed_d && (kind_d == ivt_pkg::KIND_V6) &&
                   (groups_d == ivt_pkg::V6_SEPS) && v6_ok_d) begin
        verdict_d = ivt_pkg::VERDICT_V6;
      end else begin
        verdict_d = ivt_pkg::VERDICT_NEITHER;
      end
      // string done, back to the reset state
      kind_d   = ivt_pkg::KIND_UNDECIDED;
      groups_d = '0;
      digits_d = '0;
      value_d  = '0;
      lz_d     = 1'b0;
      failed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= ivt_pkg::KIND_UNDECIDED;
      groups_q    <= '0;
      digits_q    <= '0;
      value_q     <= '0;
      lz_q        <= 1'b0;
      failed_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (consume) begin
        kind_q   <= kind_d;
        groups_q <= groups_d;
        digits_q <= digits_d;
        value_q  <= value_d;
        lz_q     <= lz_d;
        failed_q <= failed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

endmodule

/* design/ip_address_text_validator_unit.sv */
// top level of the IPv4 / IPv6 address text validator
// usage:
//   input side is a queue: drive character_i and last_i with push high; the
//   transaction is taken at a rising edge where push is high and full is low.
//   one character per transaction, last_i marks the final character.
//   result side is a single verdict register: while empty is low, verdict_o
//   holds the verdict (0 neither, 1 IPv4, 2 IPv6); pop high at a rising edge
//   with empty low takes it. only a last character produces a verdict.
// flow:
//   one character per cycle while the queue is not full and the back end is
//   not held on a last token. on its way, a last character is first written
//   into the queue as a token, and the back end then folds it into the
//   verdict register, whose output drives verdict_o.
// stalls:
//   the front end classifies characters into a token queue of DEPTH
//   entries; while the verdict register is held, the back end stops only on
//   a last token, so characters keep flowing until the queue fills, and
//   full then backs up the sender.
// reset:
//   rst_ni low clears the queue, the verdict valid flag and the string state.
`timescale 1ns / 1ps

module ip_address_text_validator_unit #(
  parameter int DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] character_i,
  input  logic       last_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] verdict_o
);

  ivt_pkg::token_t front_tok;
  ivt_pkg::token_t back_tok;
  logic            tok_valid;
  logic            tok_pop;

  // character classification
  ivt_front u_front (
    .character_i (character_i),
    .last_i      (last_i),
    .token_o     (front_tok)
  );

  // decoupling queue between classification and state update
  ivt_token_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_tok),
    .full_o  (full),
    .rd_i    (tok_pop),
    .rdata_o (back_tok),
    .valid_o (tok_valid)
  );

  // group tracking and verdict register
  ivt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (back_tok),
    .tok_pop_o   (tok_pop),
    .empty       (empty),
    .pop         (pop),
    .verdict_o   (verdict_o)
  );

endmodule
